// ----- hw/rtl/mrf_pkg.sv -----
// Shared types, constants and the CRC-16 byte update for the Modbus RTU request framer.
// No dependencies; used by every module of the framer.
package mrf_pkg;

    // Longest frame the framer will store, in bytes.
    localparam int FRAME_MAX = 256;
    localparam int POS_W     = $clog2(FRAME_MAX);
    localparam int IDX_W     = 8;
    // Frame length: 9 header/CRC bytes plus a byte count of up to 255.
    localparam int WM_OVERHEAD = 9;
    localparam int LEN_W       = $clog2(WM_OVERHEAD + 255 + 1);
    localparam int FIXED_LEN   = 8;

    localparam logic [7:0] FC_READ_REGS  = 8'h03;
    localparam logic [7:0] FC_WRITE_ONE  = 8'h06;
    localparam logic [7:0] FC_WRITE_MANY = 8'h10;

    // Positions with special meaning inside a frame
    localparam int POS_FUNC  = 1;
    localparam int POS_COUNT = 6;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 1'b1;

    typedef enum logic {
        ITEM_BYTE = 1'b0,
        ITEM_TICK = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        VERDICT_BUSY     = 3'd0,
        VERDICT_GOOD     = 3'd1,
        VERDICT_CRC_BAD  = 3'd2,
        VERDICT_BAD_FUNC = 3'd3,
        VERDICT_TIMEOUT  = 3'd4,
        VERDICT_TOO_LONG = 3'd5
    } verdict_t;

    // Item after classification by the front end
    typedef struct packed {
        kind_t            kind;
        logic [7:0]       data;
        logic             addr_hit;
        logic             fc_fixed;
        logic             fc_many;
        logic [LEN_W-1:0] wm_len;
        logic             wm_too_long;
    } cls_item_t;

    typedef struct packed {
        logic [7:0]       frame_byte;
        logic [IDX_W-1:0] byte_index;
        logic             last;
        verdict_t         verdict;
    } result_t;

    // Modbus CRC-16, reflected, one byte per call
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/mrf_front.sv -----
// Front end of the framer: classifies incoming bytes and ticks and holds them in a
// two-entry queue for the back end. Depends on mrf_pkg.
module mrf_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                func,
    input  logic [7:0]          data_byte,
    input  logic [7:0]          slave_address,
    input  logic                take,
    output logic                full,
    output logic                item_valid,
    output mrf_pkg::cls_item_t  item
);

    mrf_pkg::cls_item_t        entry_reg [2];
    mrf_pkg::cls_item_t        cls;
    logic                      wr_ptr_reg;
    logic                      wr_ptr_next;
    logic                      rd_ptr_reg;
    logic                      rd_ptr_next;
    logic [1:0]                cnt_reg;
    logic [1:0]                cnt_next;
    logic                      do_push;
    logic                      do_pop;

    always_comb
    begin
        cls.kind        = func ? mrf_pkg::ITEM_TICK : mrf_pkg::ITEM_BYTE;
        cls.data        = data_byte;
        cls.addr_hit    = (data_byte == slave_address);
        cls.fc_fixed    = (data_byte == mrf_pkg::FC_READ_REGS) ||
                          (data_byte == mrf_pkg::FC_WRITE_ONE);
        cls.fc_many     = (data_byte == mrf_pkg::FC_WRITE_MANY);
        cls.wm_len      = mrf_pkg::LEN_W'(mrf_pkg::WM_OVERHEAD) +
                          mrf_pkg::LEN_W'(data_byte);
        cls.wm_too_long = (cls.wm_len > mrf_pkg::LEN_W'(mrf_pkg::FRAME_MAX));
    end

    assign full       = (cnt_reg == 2'd2);
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = take && item_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ----- hw/rtl/mrf_back.sv -----
// Back end of the framer: frame state, running CRC, silence timer and a two-entry
// result queue. Depends on mrf_pkg.
module mrf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  mrf_pkg::cls_item_t  item,
    input  logic [15:0]         timeout_ticks,
    input  logic                pop,
    output logic                take,
    output logic                empty,
    output mrf_pkg::result_t    result
);

    logic [mrf_pkg::POS_W-1:0] pos_reg;
    logic [mrf_pkg::POS_W-1:0] pos_next;
    logic [mrf_pkg::LEN_W-1:0] exp_reg;
    logic [mrf_pkg::LEN_W-1:0] exp_next;
    logic [15:0]               crc_reg;
    logic [15:0]               crc_next;
    logic [15:0]               sil_reg;
    logic [15:0]               sil_next;
    logic                      many_reg;
    logic                      many_next;

    logic [mrf_pkg::LEN_W-1:0] pos_inc;
    logic [mrf_pkg::LEN_W-1:0] exp_eff;
    logic [15:0]               crc_upd;
    logic [15:0]               sil_inc;
    logic                      at_count;
    logic                      hunt;
    logic                      emit;
    mrf_pkg::result_t          res;

    mrf_pkg::result_t          out_reg [2];
    logic                      owr_reg;
    logic                      owr_next;
    logic                      ord_reg;
    logic                      ord_next;
    logic [1:0]                ocnt_reg;
    logic [1:0]                ocnt_next;
    logic                      out_push;
    logic                      out_pop;

    assign take     = item_valid && (ocnt_reg != 2'd2);
    assign pos_inc  = mrf_pkg::LEN_W'(pos_reg) + mrf_pkg::LEN_W'(1);
    assign crc_upd  = mrf_pkg::crc_feed((pos_reg == '0) ? mrf_pkg::CRC_INIT : crc_reg,
                                        item.data);
    assign sil_inc  = (sil_reg == 16'hFFFF) ? sil_reg : sil_reg + 16'd1;
    assign at_count = (pos_reg == mrf_pkg::POS_W'(mrf_pkg::POS_COUNT)) && many_reg;
    assign exp_eff  = at_count ? item.wm_len : exp_reg;

    always_comb
    begin
        pos_next       = pos_reg;
        exp_next       = exp_reg;
        crc_next       = crc_reg;
        sil_next       = sil_reg;
        many_next      = many_reg;
        hunt           = 1'b0;
        emit           = 1'b0;
        res.frame_byte = item.data;
        res.byte_index = mrf_pkg::IDX_W'(pos_reg);
        res.last       = 1'b0;
        res.verdict    = mrf_pkg::VERDICT_BUSY;
        if (take)
        begin
            if (item.kind == mrf_pkg::ITEM_TICK)
            begin
                if (pos_reg != '0)
                begin
                    if (sil_inc >= timeout_ticks)
                    begin
                        emit           = 1'b1;
                        hunt           = 1'b1;
                        res.frame_byte = 8'h00;
                        res.byte_index = '0;
                        res.last       = 1'b1;
                        res.verdict    = mrf_pkg::VERDICT_TIMEOUT;
                    end
                    else
                    begin
                        sil_next = sil_inc;
                    end
                end
            end
            else
            begin
                sil_next = 16'd0;
                if (pos_reg == '0)
                begin
                    if (item.addr_hit)
                    begin
                        emit     = 1'b1;
                        crc_next = crc_upd;
                        pos_next = mrf_pkg::POS_W'(1);
                    end
                end
                else
                begin
                    emit     = 1'b1;
                    crc_next = crc_upd;
                    if (pos_reg == mrf_pkg::POS_W'(mrf_pkg::POS_FUNC))
                    begin
                        if (item.fc_fixed || item.fc_many)
                        begin
                            exp_next  = item.fc_many ? '0 :
                                        mrf_pkg::LEN_W'(mrf_pkg::FIXED_LEN);
                            many_next = item.fc_many;
                            pos_next  = mrf_pkg::POS_W'(2);
                        end
                        else
                        begin
                            hunt        = 1'b1;
                            res.last    = 1'b1;
                            res.verdict = mrf_pkg::VERDICT_BAD_FUNC;
                        end
                    end
                    else if (at_count && item.wm_too_long)
                    begin
                        hunt        = 1'b1;
                        res.last    = 1'b1;
                        res.verdict = mrf_pkg::VERDICT_TOO_LONG;
                    end
                    else if ((exp_eff != '0) && (pos_inc >= exp_eff))
                    begin
                        hunt        = 1'b1;
                        res.last    = 1'b1;
                        res.verdict = (crc_upd == 16'h0000) ? mrf_pkg::VERDICT_GOOD :
                                                              mrf_pkg::VERDICT_CRC_BAD;
                    end
                    else if (pos_reg == mrf_pkg::POS_W'(mrf_pkg::FRAME_MAX - 1))
                    begin
                        hunt        = 1'b1;
                        res.last    = 1'b1;
                        res.verdict = mrf_pkg::VERDICT_TOO_LONG;
                    end
                    else
                    begin
                        pos_next = pos_reg + mrf_pkg::POS_W'(1);
                        exp_next = exp_eff;
                    end
                end
            end
            if (hunt)
            begin
                pos_next  = '0;
                exp_next  = '0;
                crc_next  = mrf_pkg::CRC_INIT;
                sil_next  = 16'd0;
                many_next = 1'b0;
            end
        end
    end

    // result queue
    assign out_push = take && emit;
    assign out_pop  = pop && (ocnt_reg != 2'd0);
    assign empty    = (ocnt_reg == 2'd0);
    assign result   = out_reg[ord_reg];

    always_comb
    begin
        owr_next  = out_push ? ~owr_reg : owr_reg;
        ord_next  = out_pop ? ~ord_reg : ord_reg;
        ocnt_next = ocnt_reg + 2'(out_push) - 2'(out_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            exp_reg  <= '0;
            crc_reg  <= mrf_pkg::CRC_INIT;
            sil_reg  <= 16'd0;
            many_reg <= 1'b0;
            owr_reg  <= 1'b0;
            ord_reg  <= 1'b0;
            ocnt_reg <= 2'd0;
        end
        else
        begin
            pos_reg  <= pos_next;
            exp_reg  <= exp_next;
            crc_reg  <= crc_next;
            sil_reg  <= sil_next;
            many_reg <= many_next;
            owr_reg  <= owr_next;
            ord_reg  <= ord_next;
            ocnt_reg <= ocnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_push)
        begin
            out_reg[owr_reg] <= res;
        end
    end

endmodule

// ----- hw/rtl/modbus_rtu_request_framer_unit.sv -----
// Top level of the Modbus RTU request framer: configuration registers, front end
// and back end. Depends on mrf_pkg, mrf_front and mrf_back.
//
//  channel   ports                                              handshake
//  input     func, data_byte                                    push / full
//  result    frame_byte, byte_index, last, verdict              pop / empty
//  config    cfg_we, cfg_index, cfg_data                        write on cfg_we
//
// One item per cycle sustained while the result queue is not full; a result passes
// through the front queue entry, then the back end's result queue, before it is on the
// outputs, and it can be popped as soon as it is there. The back end updates the frame
// state and CRC as it takes each item.
// Reset clears both queues and the frame state; no clearing pass.
// A full result queue stalls the back end, which in turn fills the front queue.
module modbus_rtu_request_framer_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          func,
    input  logic [7:0]                    data_byte,
    output logic                          empty,
    input  logic                          pop,
    output logic [7:0]                    frame_byte,
    output logic [mrf_pkg::IDX_W-1:0]     byte_index,
    output logic                          last,
    output logic [2:0]                    verdict,
    input  logic                          cfg_we,
    input  logic [mrf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data
);

    logic [7:0]          slave_address_reg;
    logic [7:0]          slave_address_next;
    logic [15:0]         timeout_ticks_reg;
    logic [15:0]         timeout_ticks_next;
    logic                item_valid;
    logic                take;
    mrf_pkg::cls_item_t  item;
    mrf_pkg::result_t    result;

    always_comb
    begin
        slave_address_next = slave_address_reg;
        timeout_ticks_next = timeout_ticks_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                mrf_pkg::REG_SLAVE_ADDRESS: slave_address_next = cfg_data[7:0];
                mrf_pkg::REG_TIMEOUT_TICKS: timeout_ticks_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_reg <= 8'd1;
            timeout_ticks_reg <= 16'd10;
        end
        else
        begin
            slave_address_reg <= slave_address_next;
            timeout_ticks_reg <= timeout_ticks_next;
        end
    end

    mrf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .func          (func),
        .data_byte     (data_byte),
        .slave_address (slave_address_reg),
        .take          (take),
        .full          (full),
        .item_valid    (item_valid),
        .item          (item)
    );

    mrf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item          (item),
        .timeout_ticks (timeout_ticks_reg),
        .pop           (pop),
        .take          (take),
        .empty         (empty),
        .result        (result)
    );

    assign frame_byte = result.frame_byte;
    assign byte_index = result.byte_index;
    assign last       = result.last;
    assign verdict    = result.verdict;

`ifndef SYNTHESIS
    // A waiting item is never dropped by the back end
    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !take |=> item_valid)
        else $error("queued item lost while back end stalled");

    // Only the final transaction of a frame carries a verdict
    a_last_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (last == (verdict != 3'(mrf_pkg::VERDICT_BUSY))))
        else $error("last and verdict disagree");

    // A timeout abort reports neither byte nor position
    a_timeout_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && (verdict == 3'(mrf_pkg::VERDICT_TIMEOUT)) |->
            (frame_byte == 8'h00) && (byte_index == '0))
        else $error("timeout result carries data");
`endif

endmodule
